// ===== design/prl_pkg.sv =====
// shared constants, codes and record type for the positional record list
`default_nettype none
package prl_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_DELETE = 3'd2;
  localparam logic [2:0] CMD_GET    = 3'd3;
  localparam logic [2:0] CMD_LOCATE = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BADPOS   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic        [55:0] name;
    logic signed [31:0] id;
    logic signed [31:0] qty;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage
`default_nettype wire

// ===== design/positional_record_list.sv =====
// top level of the positional record list: command decode, shift sequencer, search
`default_nettype none
// Ordered store of up to CAPACITY records held in one record memory with a
// registered read port. A command is taken when start is high and busy is
// low; every result beat appears on the out_ ports for exactly one cycle,
// flagged by out_valid, and cannot be held off by the receiver. Append and a
// rejected command give their result in the cycle after the command; an
// ignored code gives no result. Get reads the memory through its registered
// port, then registers the result. Insert and delete move one record at a
// time (read, then write back one slot over through the single write port),
// then finish with a closing step that writes the new record (insert) or
// lowers the count (delete). Locate streams the memory one entry a cycle,
// with an extra closing step when the final entry matches and an earlier
// match is still queued; matches come out in list order, the final one
// marked by out_last.
module positional_record_list
  import prl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic        [2:0]  in_cmd,
  input  wire logic        [7:0]  in_position,
  input  wire logic        [55:0] in_name_chars,
  input  wire logic signed [31:0] in_item_id,
  input  wire logic signed [31:0] in_quantity,
  output logic                    out_valid,
  output logic             [1:0]  out_status,
  output logic             [55:0] out_name,
  output logic signed      [31:0] out_id,
  output logic signed      [31:0] out_quantity,
  output logic                    out_last
);

  // sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SH_RD   = 3'd1;  // decide / read neighbor
  localparam logic [2:0] S_SH_WR   = 3'd2;  // write neighbor one slot over
  localparam logic [2:0] S_GET     = 3'd3;
  localparam logic [2:0] S_LOC     = 3'd4;
  localparam logic [2:0] S_LOC_END = 3'd5;  // flush last queued match

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] cursor_r, cursor_nxt;
  logic [IDX_W-1:0] pidx_r, pidx_nxt;
  logic             is_ins_r, is_ins_nxt;
  rec_t             rec_r, rec_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic             pend_r, pend_nxt;
  logic signed [31:0] pend_id_r, pend_id_nxt;
  logic signed [31:0] pend_qty_r, pend_qty_nxt;

  // memory port
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  rec_t             mem_wdata;
  logic [REC_W-1:0] mem_rdata;
  rec_t             rd_rec;

  // result beat for the output register
  logic               em_valid;
  logic [1:0]         em_status;
  logic [55:0]        em_name;
  logic signed [31:0] em_id;
  logic signed [31:0] em_qty;
  logic               em_last;

  logic             accept;
  logic [8:0]       pos9, cnt9;
  logic             bad_ins, bad_pos, full;
  logic [IDX_W-1:0] in_idx;
  logic             hit, at_end;
  rec_t             in_rec;

  prl_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(REC_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign rd_rec = rec_t'(mem_rdata);
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // position checks against the live count
  assign pos9    = {1'b0, in_position};
  assign cnt9    = 9'(count_r);
  assign bad_ins = (in_position == 8'd0) || (pos9 > cnt9 + 9'd1);
  assign bad_pos = (in_position == 8'd0) || (pos9 > cnt9);
  assign full    = (count_r == CNT_W'(CAPACITY));
  assign in_idx  = IDX_W'(in_position - 8'd1);

  assign in_rec.name = in_name_chars;
  assign in_rec.id   = in_item_id;
  assign in_rec.qty  = in_quantity;

  // search compare on the entry just read
  assign hit    = (rd_rec.id == key_r);
  assign at_end = ((CNT_W'(cursor_r) + CNT_W'(1)) == count_r);

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    cursor_nxt   = cursor_r;
    pidx_nxt     = pidx_r;
    is_ins_nxt   = is_ins_r;
    rec_nxt      = rec_r;
    key_nxt      = key_r;
    pend_nxt     = pend_r;
    pend_id_nxt  = pend_id_r;
    pend_qty_nxt = pend_qty_r;

    mem_we    = 1'b0;
    mem_waddr = cursor_r;
    mem_wdata = rec_r;
    mem_raddr = cursor_r;

    em_valid  = 1'b0;
    em_status = ST_OK;
    em_name   = '0;
    em_id     = '0;
    em_qty    = '0;
    em_last   = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_APPEND: begin
              em_valid = 1'b1;
              if (full) begin
                em_status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = IDX_W'(count_r);
                mem_wdata = in_rec;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_INSERT: begin
              if (bad_ins) begin
                em_valid  = 1'b1;
                em_status = ST_BADPOS;
              end else if (full) begin
                em_valid  = 1'b1;
                em_status = ST_FULL;
              end else begin
                rec_nxt    = in_rec;
                pidx_nxt   = in_idx;
                cursor_nxt = IDX_W'(count_r);
                is_ins_nxt = 1'b1;
                state_nxt  = S_SH_RD;
              end
            end
            CMD_DELETE: begin
              if (bad_pos) begin
                em_valid  = 1'b1;
                em_status = ST_BADPOS;
              end else begin
                pidx_nxt   = in_idx;
                cursor_nxt = in_idx;
                is_ins_nxt = 1'b0;
                state_nxt  = S_SH_RD;
              end
            end
            CMD_GET: begin
              if (bad_pos) begin
                em_valid  = 1'b1;
                em_status = ST_BADPOS;
              end else begin
                mem_raddr = in_idx;
                state_nxt = S_GET;
              end
            end
            CMD_LOCATE: begin
              key_nxt = in_item_id;
              if (count_r == '0) begin
                em_valid  = 1'b1;
                em_status = ST_NOTFOUND;
              end else begin
                mem_raddr  = '0;
                cursor_nxt = '0;
                pend_nxt   = 1'b0;
                state_nxt  = S_LOC;
              end
            end
            default: begin
              // unused codes are dropped without a result
            end
          endcase
        end
      end

      S_SH_RD: begin
        if (is_ins_r) begin
          if (cursor_r == pidx_r) begin
            // gap has reached the insert slot
            mem_we    = 1'b1;
            mem_waddr = cursor_r;
            mem_wdata = rec_r;
            count_nxt = count_r + CNT_W'(1);
            em_valid  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            mem_raddr = cursor_r - IDX_W'(1);
            state_nxt = S_SH_WR;
          end
        end else begin
          if (at_end) begin
            count_nxt = count_r - CNT_W'(1);
            em_valid  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            mem_raddr = cursor_r + IDX_W'(1);
            state_nxt = S_SH_WR;
          end
        end
      end

      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cursor_r;
        mem_wdata = rd_rec;
        cursor_nxt = is_ins_r ? (cursor_r - IDX_W'(1)) : (cursor_r + IDX_W'(1));
        state_nxt  = S_SH_RD;
      end

      S_GET: begin
        em_valid  = 1'b1;
        em_name   = rd_rec.name;
        em_id     = rd_rec.id;
        em_qty    = rd_rec.qty;
        state_nxt = S_IDLE;
      end

      S_LOC: begin
        // stream the next entry while checking this one
        mem_raddr  = cursor_r + IDX_W'(1);
        cursor_nxt = cursor_r + IDX_W'(1);
        if (!at_end) begin
          if (hit) begin
            if (pend_r) begin
              em_valid = 1'b1;
              em_id    = pend_id_r;
              em_qty   = pend_qty_r;
              em_last  = 1'b0;
            end
            pend_nxt     = 1'b1;
            pend_id_nxt  = rd_rec.id;
            pend_qty_nxt = rd_rec.qty;
          end
        end else begin
          state_nxt = S_IDLE;
          if (hit && pend_r) begin
            em_valid     = 1'b1;
            em_id        = pend_id_r;
            em_qty       = pend_qty_r;
            em_last      = 1'b0;
            pend_id_nxt  = rd_rec.id;
            pend_qty_nxt = rd_rec.qty;
            state_nxt    = S_LOC_END;
          end else if (hit) begin
            em_valid = 1'b1;
            em_id    = rd_rec.id;
            em_qty   = rd_rec.qty;
          end else if (pend_r) begin
            em_valid = 1'b1;
            em_id    = pend_id_r;
            em_qty   = pend_qty_r;
          end else begin
            em_valid  = 1'b1;
            em_status = ST_NOTFOUND;
          end
        end
      end

      S_LOC_END: begin
        em_valid  = 1'b1;
        em_id     = pend_id_r;
        em_qty    = pend_qty_r;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      pend_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      pend_r    <= pend_nxt;
      out_valid <= em_valid;
    end
  end

  // working registers and result beat payload
  always_ff @(posedge clk) begin
    cursor_r   <= cursor_nxt;
    pidx_r     <= pidx_nxt;
    is_ins_r   <= is_ins_nxt;
    rec_r      <= rec_nxt;
    key_r      <= key_nxt;
    pend_id_r  <= pend_id_nxt;
    pend_qty_r <= pend_qty_nxt;
    if (em_valid) begin
      out_status   <= em_status;
      out_name     <= em_name;
      out_id       <= em_id;
      out_quantity <= em_qty;
      out_last     <= em_last;
    end
  end

endmodule
`default_nettype wire

// ===== design/prl_ram.sv =====
// single-port-write, registered-read record memory
`default_nettype none
module prl_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 120,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
